[hw/rtl/plp_pkg.sv]
// ============================================================================
// Per-line palette pixel decoder package
// Shared types, constants and color expansion helpers.
// ============================================================================
package plp_pkg;

    localparam int WORD_W    = 16;
    localparam int SLOT_W    = 6;
    localparam int PAL_DEPTH = 48;
    localparam int PX_W      = 9;
    localparam int BANK_SPAN = 160;
    localparam int CH_W      = 8;

    localparam logic CMD_PAL_WRITE = 1'b0;
    localparam logic CMD_PIXELS    = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CH_W-1:0]   t_chan;

    typedef struct packed {
        t_slot addr;
        logic  last;
        logic  eol;
    } t_rd_req;

    typedef struct packed {
        logic busy;
        logic last;
    } t_ser_stat;

    localparam logic [7:0] SCALE5 [32] = '{
        8'h00, 8'h08, 8'h10, 8'h18, 8'h20, 8'h29, 8'h31, 8'h39,
        8'h41, 8'h4a, 8'h52, 8'h5a, 8'h62, 8'h6a, 8'h73, 8'h7b,
        8'h83, 8'h8b, 8'h94, 8'h9c, 8'ha4, 8'hac, 8'hb4, 8'hbd,
        8'hc5, 8'hcd, 8'hd5, 8'hde, 8'he6, 8'hee, 8'hf6, 8'hff
    };

    // Bank boundary: 10*c+1 for even indexes, 10*c-5 for odd ones.
    function automatic logic [PX_W-1:0] bank_bound(input logic [3:0] c);
        logic [PX_W-1:0] b;
        b = PX_W'(c) * PX_W'(10);
        if (c[0]) begin
            b = b - PX_W'(5);
        end else begin
            b = b + PX_W'(1);
        end
        return b;
    endfunction

    function automatic t_chan expand_ch(input logic [3:0] v, input logic ext,
                                        input logic enh);
        t_chan r;
        if (enh) begin
            r = SCALE5[{v, ext}];
        end else begin
            r = {v, v};
        end
        return r;
    endfunction

endpackage

[hw/rtl/per_line_palette_pixel_decoder_core.sv]
// ============================================================================
// Per-line palette pixel decoder
// Turns four bit-plane words into sixteen RGB pixels through a 48-entry
// position-dependent line palette.
// ============================================================================
// Pipeline: plane words are registered in the serializer, each pixel's palette
// entry is registered by the read port and its color at the output; pixels
// come one per cycle while the output is not stalled. A new group is taken
// as the previous group's last pixel is read; a palette write yields no pixel.
// Reset: synchronous, active low; clears the palette valid bits, the line
// position, the enhanced mode bit and all pipeline valid flags.
module per_line_palette_pixel_decoder_core #(
    parameter int LINE_WIDTH = 320
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_cmd,
    input  plp_pkg::t_slot i_palette_slot,
    input  plp_pkg::t_word i_palette_word,
    input  plp_pkg::t_word i_plane0,
    input  plp_pkg::t_word i_plane1,
    input  plp_pkg::t_word i_plane2,
    input  plp_pkg::t_word i_plane3,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_enhanced_mode,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output plp_pkg::t_chan o_red,
    output plp_pkg::t_chan o_green,
    output plp_pkg::t_chan o_blue,
    output logic           o_last_of_group,
    output logic           o_end_of_line
);
    import plp_pkg::*;

    t_ser_stat ser_stat;
    t_rd_req   rd_req;
    t_word     rd_word;
    logic      in_fire, load, pal_wr;
    logic      s_adv, m_ready, o_load_ok;

    logic  r_enh;
    logic  r_m_valid, r_m_last, r_m_eol;
    logic  r_o_valid, r_o_last, r_o_eol;
    t_chan r_red, r_green, r_blue;

    assign o_load_ok  = !r_o_valid || i_out_ready;
    assign m_ready    = !r_m_valid || o_load_ok;
    assign s_adv      = ser_stat.busy && m_ready;
    assign o_in_ready = !ser_stat.busy || (ser_stat.last && s_adv);
    assign in_fire    = i_in_valid && o_in_ready;
    assign load       = in_fire && (i_cmd == CMD_PIXELS);
    assign pal_wr     = in_fire && (i_cmd == CMD_PAL_WRITE)
                        && (i_palette_slot < SLOT_W'(PAL_DEPTH));
    assign o_cfg_ready = 1'b1;

    plp_serializer #(
        .LINE_WIDTH(LINE_WIDTH)
    ) u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_plane0(i_plane0),
        .i_plane1(i_plane1),
        .i_plane2(i_plane2),
        .i_plane3(i_plane3),
        .i_adv   (s_adv),
        .o_stat  (ser_stat),
        .o_req   (rd_req)
    );

    plp_palette u_pal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (pal_wr),
        .i_wr_addr(i_palette_slot),
        .i_wr_data(i_palette_word),
        .i_rd_en  (s_adv),
        .i_rd_addr(rd_req.addr),
        .o_rd_data(rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enh     <= 1'b0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_enh <= i_cfg_enhanced_mode;
            end
            if (m_ready) begin
                r_m_valid <= s_adv;
            end
            if (o_load_ok) begin
                r_o_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_m_last <= rd_req.last;
            r_m_eol  <= rd_req.eol;
        end
        if (o_load_ok && r_m_valid) begin
            r_red    <= expand_ch({rd_word[10:8], rd_word[11]}, rd_word[15], r_enh);
            r_green  <= expand_ch({rd_word[6:4], rd_word[7]}, rd_word[14], r_enh);
            r_blue   <= expand_ch({rd_word[2:0], rd_word[3]}, rd_word[13], r_enh);
            r_o_last <= r_m_last;
            r_o_eol  <= r_m_eol;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_red           = r_red;
    assign o_green         = r_green;
    assign o_blue          = r_blue;
    assign o_last_of_group = r_o_last;
    assign o_end_of_line   = r_o_eol;

endmodule

[hw/rtl/plp_palette.sv]
// ============================================================================
// Line palette store
// 48-entry color memory with per-entry valid bits cleared at reset and a
// registered read port; an entry never written reads as zero.
// ============================================================================
module plp_palette (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  plp_pkg::t_slot i_wr_addr,
    input  plp_pkg::t_word i_wr_data,
    input  logic          i_rd_en,
    input  plp_pkg::t_slot i_rd_addr,
    output plp_pkg::t_word o_rd_data
);
    import plp_pkg::*;

    t_word r_mem [PAL_DEPTH];
    logic  [PAL_DEPTH-1:0] r_vld;
    t_word r_rd_data;
    logic  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

[hw/rtl/plp_serializer.sv]
// ============================================================================
// Pixel group serializer
// Holds one group of four plane words, steps through its sixteen pixels and
// tracks the line position to form each pixel's palette address.
// ============================================================================
module plp_serializer #(
    parameter int LINE_WIDTH = 320
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  plp_pkg::t_word    i_plane0,
    input  plp_pkg::t_word    i_plane1,
    input  plp_pkg::t_word    i_plane2,
    input  plp_pkg::t_word    i_plane3,
    input  logic              i_adv,
    output plp_pkg::t_ser_stat o_stat,
    output plp_pkg::t_rd_req  o_req
);
    import plp_pkg::*;

    localparam int XW = $clog2(LINE_WIDTH);

    logic          r_busy, n_busy;
    logic [3:0]    r_cnt, n_cnt;
    logic [XW-1:0] r_x, n_x;
    t_word         r_planes [4];

    logic [3:0]      bit_sel;
    logic [3:0]      color;
    logic [PX_W-1:0] x_ext;
    logic [PX_W-1:0] bound;
    logic [1:0]      bank;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_x    = r_x;
        if (i_adv) begin
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                n_busy = 1'b0;
            end
            if (r_x == XW'(LINE_WIDTH - 1)) begin
                n_x = '0;
            end else begin
                n_x = r_x + XW'(1);
            end
        end
        if (i_load) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_x    <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_x    <= n_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_planes[0] <= i_plane0;
            r_planes[1] <= i_plane1;
            r_planes[2] <= i_plane2;
            r_planes[3] <= i_plane3;
        end
    end

    always_comb begin
        bit_sel = ~r_cnt;
        color   = {r_planes[3][bit_sel], r_planes[2][bit_sel],
                   r_planes[1][bit_sel], r_planes[0][bit_sel]};
        x_ext   = PX_W'(r_x);
        bound   = bank_bound(color);
        if (x_ext >= bound + PX_W'(BANK_SPAN)) begin
            bank = 2'd2;
        end else if (x_ext >= bound) begin
            bank = 2'd1;
        end else begin
            bank = 2'd0;
        end
    end

    assign o_req.addr  = {bank, color};
    assign o_req.last  = (r_cnt == 4'd15);
    assign o_req.eol   = (r_x == XW'(LINE_WIDTH - 1));
    assign o_stat.busy = r_busy;
    assign o_stat.last = (r_cnt == 4'd15);

endmodule

[hw/rtl/plp_checker.sv]
// ============================================================================
// Per-line palette pixel decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ============================================================================
module plp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_cmd,
    input logic       o_cfg_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic       o_last_of_group,
    input logic       o_end_of_line
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_red)
            && $stable(o_green) && $stable(o_blue)
            && $stable(o_last_of_group) && $stable(o_end_of_line))
        else $error("Stalled pixel transaction changed.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Pixel output valid right after reset.");

    a_group_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd |=> !o_in_ready)
        else $error("New transaction taken before a group was serialized.");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_cfg_ready)
        else $error("Configuration port not ready.");

endmodule

bind per_line_palette_pixel_decoder_core plp_checker u_plp_checker (.*);
